[sv/imadec_pkg.sv]
`timescale 1ns / 1ps

package imadec_pkg;

   typedef logic signed [15:0] pcm_type;
   typedef logic [6:0]         index_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_flag;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               last;
   } rsp_word_type;

   typedef struct packed {
      pcm_type   predictor;
      index_type step_index;
   } codec_state_type;

   localparam index_type         MAX_INDEX  = 7'd88;
   localparam logic [2:0]        MAX_SHIFT  = 3'd6;
   localparam logic [2:0]        HEADER_LEN = 3'd4;
   localparam logic [7:0]        INDEX_MASK = 8'h7F;
   localparam logic signed [17:0] PCM_MAX   = 18'sh07FFF;
   localparam logic signed [17:0] PCM_MIN   = -18'sh07FFF;

   localparam logic [2:0] HDR_PRED_LO = 3'd0;
   localparam logic [2:0] HDR_PRED_HI = 3'd1;
   localparam logic [2:0] HDR_INDEX   = 3'd2;

   localparam logic REG_DECIM_SHIFT = 1'b0;

   localparam logic [15:0] STEP_TABLE [89] = '{
      16'h0007, 16'h0008, 16'h0009, 16'h000A, 16'h000B, 16'h000C, 16'h000D, 16'h000E,
      16'h0010, 16'h0011, 16'h0013, 16'h0015, 16'h0017, 16'h0019, 16'h001C, 16'h001F,
      16'h0022, 16'h0025, 16'h0029, 16'h002D, 16'h0032, 16'h0037, 16'h003C, 16'h0042,
      16'h0049, 16'h0050, 16'h0058, 16'h0061, 16'h006B, 16'h0076, 16'h0082, 16'h008F,
      16'h009D, 16'h00AD, 16'h00BE, 16'h00D1, 16'h00E6, 16'h00FD, 16'h0117, 16'h0133,
      16'h0151, 16'h0173, 16'h0198, 16'h01C1, 16'h01EE, 16'h0220, 16'h0256, 16'h0292,
      16'h02D4, 16'h031C, 16'h036C, 16'h03C3, 16'h0424, 16'h048E, 16'h0502, 16'h0583,
      16'h0610, 16'h06AB, 16'h0756, 16'h0812, 16'h08E0, 16'h09C3, 16'h0ABD, 16'h0BD0,
      16'h0CFF, 16'h0E4C, 16'h0FBA, 16'h114C, 16'h1307, 16'h14EE, 16'h1706, 16'h1954,
      16'h1BDC, 16'h1EA5, 16'h21B6, 16'h2515, 16'h28CA, 16'h2CDF, 16'h315B, 16'h364B,
      16'h3BB9, 16'h41B2, 16'h4844, 16'h4F7E, 16'h5771, 16'h602F, 16'h69CE, 16'h7462,
      16'h7FFF
   };

   function automatic logic [15:0] step_lookup(input index_type idx);
      index_type clamped;
      clamped = (idx > MAX_INDEX) ? MAX_INDEX : idx;
      return STEP_TABLE[clamped];
   endfunction

   // -1 for magnitudes 0..3, then 2, 4, 6, 8
   function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
      logic signed [4:0] adj;
      if (mag[2]) begin
         adj = $signed({2'b00, mag[1:0], 1'b0}) + 5'sd2;
      end else begin
         adj = -5'sd1;
      end
      return adj;
   endfunction

endpackage

[sv/imadec_nibble.sv]
`timescale 1ns / 1ps

module imadec_nibble (
   input  imadec_pkg::codec_state_type state_in,
   input  logic [3:0]                  code,
   output imadec_pkg::codec_state_type state_out
);

   logic [15:0]        step;
   logic [16:0]        diff;
   logic signed [17:0] pred_ext;
   logic signed [17:0] val;
   logic signed [8:0]  idx_next;

   always_comb begin
      step = imadec_pkg::step_lookup(state_in.step_index);
      diff = {4'b0, step[15:3]};
      if (code[0]) diff = diff + {3'b0, step[15:2]};
      if (code[1]) diff = diff + {2'b0, step[15:1]};
      if (code[2]) diff = diff + {1'b0, step};

      pred_ext = 18'(state_in.predictor);
      if (code[3]) begin
         val = pred_ext - $signed({1'b0, diff});
         if (val < imadec_pkg::PCM_MIN) val = imadec_pkg::PCM_MIN;
      end else begin
         val = pred_ext + $signed({1'b0, diff});
         if (val > imadec_pkg::PCM_MAX) val = imadec_pkg::PCM_MAX;
      end

      idx_next = $signed({2'b00, state_in.step_index})
               + 9'(imadec_pkg::index_adjust(code[2:0]));
      if (idx_next < 9'sd0) begin
         idx_next = 9'sd0;
      end else if (idx_next > $signed({2'b00, imadec_pkg::MAX_INDEX})) begin
         idx_next = $signed({2'b00, imadec_pkg::MAX_INDEX});
      end

      state_out.predictor  = val[15:0];
      state_out.step_index = idx_next[6:0];
   end

endmodule

[sv/ima_adpcm_sample_decoder_core.sv]
`timescale 1ns / 1ps
// Sample words are queued as their byte is taken and offered on rsp from the head.
// Bytes are taken one per cycle while rsp is not stalled and at most one nibble of
//   each byte is emitted; else req_stall holds bytes back as the single result port
//   drains the FIFO_DEPTH-entry queue. Both nibble steps are chained combinationally.
// Reset clears header count, predictor, step index, nibble phase, decim_shift, queue.
module ima_adpcm_sample_decoder_core #(
   parameter int FIFO_DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  imadec_pkg::req_word_type   req_word,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output imadec_pkg::rsp_word_type   rsp_word,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [2:0]                 paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   localparam int PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CntW = $clog2(FIFO_DEPTH + 1);

   logic [2:0]                  decim_shift_ff, decim_shift_in;
   logic [2:0]                  header_count_ff, header_count_in;
   imadec_pkg::pcm_type         predictor_ff, predictor_in;
   imadec_pkg::index_type       step_index_ff, step_index_in;
   logic [5:0]                  phase_ff, phase_in;

   imadec_pkg::rsp_word_type    queue_ff [FIFO_DEPTH];
   logic [PtrW-1:0]             wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]             count_ff, count_in;

   logic                        accept, pop, cfg_write;
   logic [2:0]                  hc_eff, shift_eff;
   logic [5:0]                  phase_eff, mask;
   logic                        is_header, emit0, emit1;
   logic [1:0]                  n_wr;
   imadec_pkg::codec_state_type cur_state, mid_state, end_state;
   imadec_pkg::rsp_word_type    wr_word0, wr_word1;
   logic [7:0]                  hdr_index;

   function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
      return (p == PtrW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready
                   && (paddr[2] == imadec_pkg::REG_DECIM_SHIFT);
   assign prdata    = (paddr[2] == imadec_pkg::REG_DECIM_SHIFT) ?
                      {29'b0, decim_shift_ff} : 32'b0;
   assign decim_shift_in = cfg_write ? pwdata[2:0] : decim_shift_ff;

   assign req_stall = count_ff > CntW'(FIFO_DEPTH - 2);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = count_ff != '0;
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_word  = queue_ff[rd_ptr_ff];

   assign cur_state.predictor  = predictor_ff;
   assign cur_state.step_index = step_index_ff;

   imadec_nibble u_nib_lo (
      .state_in  (cur_state),
      .code      (req_word.data_byte[3:0]),
      .state_out (mid_state)
   );

   imadec_nibble u_nib_hi (
      .state_in  (mid_state),
      .code      (req_word.data_byte[7:4]),
      .state_out (end_state)
   );

   always_comb begin
      hc_eff    = req_word.start_flag ? 3'd0 : header_count_ff;
      phase_eff = req_word.start_flag ? 6'd0 : phase_ff;
      is_header = hc_eff < imadec_pkg::HEADER_LEN;
      shift_eff = (decim_shift_ff > imadec_pkg::MAX_SHIFT) ?
                  imadec_pkg::MAX_SHIFT : decim_shift_ff;
      mask      = 6'((7'd1 << shift_eff) - 7'd1);
      emit0     = (phase_eff & mask) == 6'd0;
      emit1     = ((phase_eff + 6'd1) & mask) == 6'd0;
      hdr_index = req_word.data_byte & imadec_pkg::INDEX_MASK;

      header_count_in = header_count_ff;
      predictor_in    = predictor_ff;
      step_index_in   = step_index_ff;
      phase_in        = phase_ff;
      n_wr            = 2'd0;

      if (accept) begin
         if (is_header) begin
            header_count_in = hc_eff + 3'd1;
            phase_in        = phase_eff;
            case (hc_eff)
               imadec_pkg::HDR_PRED_LO: begin
                  predictor_in = {predictor_ff[15:8], req_word.data_byte};
                  phase_in     = 6'd0;
               end
               imadec_pkg::HDR_PRED_HI: begin
                  predictor_in = {req_word.data_byte, predictor_ff[7:0]};
               end
               imadec_pkg::HDR_INDEX: begin
                  step_index_in = (hdr_index > {1'b0, imadec_pkg::MAX_INDEX}) ?
                                  imadec_pkg::MAX_INDEX : hdr_index[6:0];
               end
               default: begin
               end
            endcase
         end else begin
            predictor_in  = end_state.predictor;
            step_index_in = end_state.step_index;
            phase_in      = phase_eff + 6'd2;
            n_wr          = {1'b0, emit0} + {1'b0, emit1};
         end
      end

      wr_word0.sample = emit0 ? mid_state.predictor : end_state.predictor;
      wr_word0.last   = !(emit0 && emit1);
      wr_word1.sample = end_state.predictor;
      wr_word1.last   = 1'b1;

      wr_ptr_in = wr_ptr_ff;
      if (n_wr == 2'd1) wr_ptr_in = ptr_next(wr_ptr_ff);
      if (n_wr == 2'd2) wr_ptr_in = ptr_next(ptr_next(wr_ptr_ff));
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CntW'(n_wr) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (n_wr != 2'd0) queue_ff[wr_ptr_ff] <= wr_word0;
      if (n_wr == 2'd2) queue_ff[ptr_next(wr_ptr_ff)] <= wr_word1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decim_shift_ff  <= '0;
         header_count_ff <= '0;
         predictor_ff    <= '0;
         step_index_ff   <= '0;
         phase_ff        <= '0;
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         count_ff        <= '0;
      end else begin
         decim_shift_ff  <= decim_shift_in;
         header_count_ff <= header_count_in;
         predictor_ff    <= predictor_in;
         step_index_ff   <= step_index_in;
         phase_ff        <= phase_in;
         wr_ptr_ff       <= wr_ptr_in;
         rd_ptr_ff       <= rd_ptr_in;
         count_ff        <= count_in;
      end
   end

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(FIFO_DEPTH))
      else $error("result queue overflow");

   a_header_no_word: assert property (@(posedge clock) disable iff (reset)
      (accept && is_header) |=> count_ff <= $past(count_ff))
      else $error("header byte produced a result word");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      step_index_ff <= imadec_pkg::MAX_INDEX)
      else $error("step index out of range");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (count_ff == '0 && !rsp_valid))
      else $error("queue not empty after reset");

endmodule

[tb/sv/tb_ima_adpcm_sample_decoder_core.sv]
`timescale 1ns / 1ps

module tb_ima_adpcm_sample_decoder_core;

   localparam int          CYCLE_LIMIT  = 1000000;
   localparam int          PHASE_ITEMS  = 220;
   localparam int          DRAIN_CYCLES = 8;
   localparam int          LONG_HOLD    = 300;
   localparam int          NUM_PHASES   = 9;
   localparam int          SCRIPT_LEN   = 25;
   localparam logic [2:0]  DECIM_ADDR   = {imadec_pkg::REG_DECIM_SHIFT, 2'b00};

   typedef struct packed {
      logic [7:0]          data;
      logic                start;
      logic                typed;
      imadec_pkg::pcm_type first;
      imadec_pkg::pcm_type second;
   } script_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   imadec_pkg::req_word_type req_word = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   imadec_pkg::rsp_word_type rsp_word;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [2:0]               paddr = '0;
   logic [31:0]              pwdata = '0;
   logic [31:0]              prdata;
   logic                     pready;

   // decoder state mirror
   logic [2:0]               hdr_count = '0;
   imadec_pkg::pcm_type      acc_pcm = '0;
   imadec_pkg::index_type    acc_index = '0;
   logic [5:0]               nib_pos = '0;
   logic [2:0]               decim_cfg = '0;

   imadec_pkg::rsp_word_type pending_samples [$];
   int                       mismatches = 0;
   int                       cycle_count = 0;
   int                       phase_items;
   bit                       req_no_gap = 1'b0;
   bit                       rsp_no_gap = 1'b0;
   bit                       long_hold_due = 1'b0;

   // header without start, index clamp, both predictor clamps, restart mid header,
   // nibble codes 0 to D, start on a data byte
   script_row_type script [SCRIPT_LEN] = '{
      '{8'h00, 1'b0, 1'b0, 16'sh0000, 16'sh0000},
      '{8'h80, 1'b0, 1'b0, 16'sh0000, 16'sh0000},
      '{8'hFF, 1'b0, 1'b0, 16'sh0000, 16'sh0000},
      '{8'h00, 1'b0, 1'b0, 16'sh0000, 16'sh0000},
      '{8'h88, 1'b0, 1'b1, 16'sh8001, 16'sh8001},
      '{8'hFF, 1'b1, 1'b0, 16'sh0000, 16'sh0000},
      '{8'h7F, 1'b0, 1'b0, 16'sh0000, 16'sh0000},
      '{8'h58, 1'b0, 1'b0, 16'sh0000, 16'sh0000},
      '{8'hAA, 1'b0, 1'b0, 16'sh0000, 16'sh0000},
      '{8'h77, 1'b0, 1'b1, 16'sh7FFF, 16'sh7FFF},
      '{8'h00, 1'b1, 1'b0, 16'sh0000, 16'sh0000},
      '{8'h00, 1'b0, 1'b0, 16'sh0000, 16'sh0000},
      '{8'h00, 1'b1, 1'b0, 16'sh0000, 16'sh0000},
      '{8'h00, 1'b0, 1'b0, 16'sh0000, 16'sh0000},
      '{8'h00, 1'b0, 1'b0, 16'sh0000, 16'sh0000},
      '{8'h00, 1'b0, 1'b0, 16'sh0000, 16'sh0000},
      '{8'h10, 1'b0, 1'b1, 16'sh0000, 16'sh0001},
      '{8'h32, 1'b0, 1'b1, 16'sh0004, 16'sh0008},
      '{8'h54, 1'b0, 1'b1, 16'sh000F, 16'sh001B},
      '{8'h76, 1'b0, 1'b0, 16'sh0000, 16'sh0000},
      '{8'h98, 1'b0, 1'b0, 16'sh0000, 16'sh0000},
      '{8'hBA, 1'b0, 1'b0, 16'sh0000, 16'sh0000},
      '{8'hDC, 1'b0, 1'b0, 16'sh0000, 16'sh0000},
      '{8'hFE, 1'b1, 1'b0, 16'sh0000, 16'sh0000},
      '{8'hF0, 1'b0, 1'b0, 16'sh0000, 16'sh0000}
   };

   logic [2:0] decim_plan [NUM_PHASES] = '{3'd1, 3'd7, 3'd6, 3'd0, 3'd2, 3'd3, 3'd4, 3'd5, 3'd0};

   ima_adpcm_sample_decoder_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d samples outstanding", $time, pending_samples.size());
         $display("tb_ima_adpcm_sample_decoder_core: FAIL");
         $finish;
      end
   end

   // one code step; returns whether the decimator lets the sample out
   function automatic bit decode_nibble(input logic [3:0] code,
                                        output imadec_pkg::pcm_type pcm);
      logic [15:0] step;
      int          delta;
      int          acc;
      int          adj;
      int          next_index;
      int          shift;
      bit          emit;
      step = imadec_pkg::STEP_TABLE[(acc_index > imadec_pkg::MAX_INDEX) ?
                                    imadec_pkg::MAX_INDEX : acc_index];
      delta = step >> 3;
      if (code[0]) delta += step >> 2;
      if (code[1]) delta += step >> 1;
      if (code[2]) delta += step;
      acc = acc_pcm;
      if (code[3]) begin
         acc -= delta;
         if (acc < -32767) acc = -32767;
      end else begin
         acc += delta;
         if (acc > 32767) acc = 32767;
      end
      if (code[2]) adj = 2 * int'(code[1:0]) + 2;
      else adj = -1;
      next_index = int'(acc_index) + adj;
      if (next_index < 0) next_index = 0;
      else if (next_index > int'(imadec_pkg::MAX_INDEX)) next_index = int'(imadec_pkg::MAX_INDEX);
      acc_pcm = imadec_pkg::pcm_type'(acc);
      acc_index = imadec_pkg::index_type'(next_index);
      shift = (decim_cfg > imadec_pkg::MAX_SHIFT) ? int'(imadec_pkg::MAX_SHIFT) : int'(decim_cfg);
      emit = (int'(nib_pos) % (1 << shift)) == 0;
      nib_pos = nib_pos + 6'd1;
      pcm = acc_pcm;
      return emit;
   endfunction

   task automatic decode_byte(input imadec_pkg::req_word_type w,
                              output imadec_pkg::rsp_word_type words [2],
                              output int n);
      imadec_pkg::pcm_type   pcm;
      imadec_pkg::index_type ix;
      n = 0;
      words[0] = '0;
      words[1] = '0;
      if (w.start_flag) begin
         hdr_count = '0;
         nib_pos = '0;
      end
      if (hdr_count < imadec_pkg::HEADER_LEN) begin
         case (hdr_count)
            imadec_pkg::HDR_PRED_LO: begin
               acc_pcm[7:0] = w.data_byte;
               nib_pos = '0;
            end
            imadec_pkg::HDR_PRED_HI: begin
               acc_pcm[15:8] = w.data_byte;
            end
            imadec_pkg::HDR_INDEX: begin
               ix = imadec_pkg::index_type'(w.data_byte & imadec_pkg::INDEX_MASK);
               acc_index = (ix > imadec_pkg::MAX_INDEX) ? imadec_pkg::MAX_INDEX : ix;
            end
            default: ;
         endcase
         hdr_count = hdr_count + 3'd1;
      end else begin
         if (decode_nibble(w.data_byte[3:0], pcm)) begin
            words[n].sample = pcm;
            n++;
         end
         if (decode_nibble(w.data_byte[7:4], pcm)) begin
            words[n].sample = pcm;
            n++;
         end
         if (n > 0) words[n - 1].last = 1'b1;
      end
   endtask

   task automatic send_byte(input logic [7:0] data, input logic start,
                            input logic typed = 1'b0,
                            input imadec_pkg::pcm_type first = '0,
                            input imadec_pkg::pcm_type second = '0);
      int                       gap;
      int                       n;
      imadec_pkg::rsp_word_type words [2];
      imadec_pkg::req_word_type w;
      w.data_byte = data;
      w.start_flag = start;
      gap = req_no_gap ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      decode_byte(w, words, n);
      if (typed) begin
         words[0].sample = first;
         words[1].sample = second;
      end
      for (int i = 0; i < n; i++) pending_samples.push_back(words[i]);
      phase_items++;
   endtask

   task automatic drain;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write the decimation register, then read it back
   task automatic csr_update(input logic [2:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= DECIM_ADDR;
      pwdata <= {29'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      decim_cfg = value;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[2:0] !== decim_cfg) begin
         $display("%0t: decim_shift readback expected %0d actual %0d",
                  $time, decim_cfg, prdata[2:0]);
         mismatches++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // receiver: random stall per word, one long hold on request
   initial begin : rsp_side
      int hold;
      forever begin
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            hold = LONG_HOLD;
         end else begin
            hold = rsp_no_gap ? 0 : $urandom_range(0, 8);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin : rsp_check
      imadec_pkg::rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_samples.size() == 0) begin
            $display("%0t: unexpected word, expected none actual sample %0d last %0b",
                     $time, rsp_word.sample, rsp_word.last);
            mismatches++;
         end else begin
            want = pending_samples.pop_front();
            if (rsp_word.sample !== want.sample) begin
               $display("%0t: sample expected %0d actual %0d",
                        $time, want.sample, rsp_word.sample);
               mismatches++;
            end
            if (rsp_word.last !== want.last) begin
               $display("%0t: last expected %0b actual %0b", $time, want.last, rsp_word.last);
               mismatches++;
            end
         end
      end
   end

   initial begin : req_side
      int  kind;
      int  hdr_len;
      int  data_len;
      bit  paused;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < SCRIPT_LEN; i++)
         send_byte(script[i].data, script[i].start, script[i].typed,
                   script[i].first, script[i].second);
      req_valid <= 1'b0;
      drain();

      for (int p = 0; p < NUM_PHASES; p++) begin
         csr_update((p == NUM_PHASES - 1) ? 3'($urandom_range(0, 7)) : decim_plan[p]);
         req_no_gap = (p % 3 == 1) || (p == 3);
         rsp_no_gap = (p % 3 == 2);
         if (p == 3) long_hold_due = 1'b1;
         paused = 1'b0;
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            if (p == 4 && !paused && phase_items >= PHASE_ITEMS / 2) begin
               paused = 1'b1;
               req_valid <= 1'b0;
               drain();
            end
            kind = $urandom_range(0, 15);
            if (kind == 0) begin
               send_byte(8'($urandom), 1'($urandom));
            end else begin
               hdr_len = (kind == 1) ? $urandom_range(0, 2) : 3;
               send_byte(8'($urandom), 1'b1);
               repeat (hdr_len) send_byte(8'($urandom), 1'b0);
               if (kind != 1) begin
                  data_len = $urandom_range(1, 48);
                  repeat (data_len) send_byte(8'($urandom), 1'b0);
               end
            end
         end
         req_valid <= 1'b0;
         drain();
      end

      if (mismatches == 0) begin
         $display("tb_ima_adpcm_sample_decoder_core: PASS");
      end else begin
         $display("tb_ima_adpcm_sample_decoder_core: FAIL");
      end
      $finish;
   end

endmodule

[ima_adpcm_sample_decoder_core.f]
sv/imadec_pkg.sv
sv/imadec_nibble.sv
sv/ima_adpcm_sample_decoder_core.sv
tb/sv/tb_ima_adpcm_sample_decoder_core.sv
